### sv/ppls_pkg.sv
// ----------------------------------------------------------------------------
// Phong point-light shader package
// Shared widths, sequencer states and small helper functions.
// ----------------------------------------------------------------------------
package ppls_pkg;

  localparam int unsigned MAX_LIGHTS_DEF = 16;
  localparam int unsigned MUL_W          = 32;
  localparam int unsigned PROD_W         = 64;
  localparam int unsigned SQRT_IN_W      = 62;
  localparam int unsigned ROOT_W         = 31;
  localparam int unsigned MAG_W          = 22;
  localparam int unsigned QUOT_W         = 16;
  localparam int unsigned SUM_W          = 24;

  localparam logic [47:0] ONE3_Q412      = 48'h1000_1000_1000;
  localparam logic [7:0]  SHIN_RESET     = 8'd20;
  localparam logic [15:0] ONE_Q13        = 16'd8192;

  typedef enum logic [1:0] {
    REG_MAT_AMB  = 2'd0,
    REG_MAT_DIF  = 2'd1,
    REG_MAT_SPEC = 2'd2,
    REG_SHIN     = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AMB,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_LN,
    ST_REFL,
    ST_VR,
    ST_POW,
    ST_ACC,
    ST_FIN
  } state_e;

  function automatic logic [15:0] chan16(input logic [47:0] v, input logic [1:0] c);
    logic [15:0] r;
    case (c)
      2'd0:    r = v[47:32];
      2'd1:    r = v[31:16];
      default: r = v[15:0];
    endcase
    return r;
  endfunction

  function automatic logic [20:0] comp21(input logic [62:0] v, input logic [1:0] c);
    logic [20:0] r;
    case (c)
      2'd0:    r = v[62:42];
      2'd1:    r = v[41:21];
      default: r = v[20:0];
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [47:0] b);
    logic [48:0] s;
    s = 49'(a) + 49'(b);
    return (s > 49'hFF_FFFF) ? 24'hFF_FFFF : s[SUM_W-1:0];
  endfunction

endpackage

### sv/ppls_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32x32 multiply with a registered product.
// ----------------------------------------------------------------------------
module ppls_mul (
  input  logic                                  clk_i,
  input  logic signed [ppls_pkg::MUL_W-1:0]     a_i,
  input  logic signed [ppls_pkg::MUL_W-1:0]     b_i,
  output logic signed [ppls_pkg::PROD_W-1:0]    p_o
);

  logic signed [ppls_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### sv/ppls_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ppls_isqrt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ppls_pkg::SQRT_IN_W-1:0]      x_i,
  output logic                                done_o,
  output logic [ppls_pkg::ROOT_W-1:0]         root_o
);

  localparam int unsigned RW = ppls_pkg::ROOT_W;

  logic [ppls_pkg::SQRT_IN_W-1:0] x_q, x_d;
  logic [RW+1:0]                  rem_q, rem_d;
  logic [RW-1:0]                  root_q, root_d;
  logic [4:0]                     cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [RW+3:0]                  tmp, trial;

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    tmp    = {rem_q, x_q[ppls_pkg::SQRT_IN_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    if (start_i) begin
      x_d    = x_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = {x_q[ppls_pkg::SQRT_IN_W-3:0], 2'b00};
      if (tmp >= trial) begin
        rem_d  = (RW+2)'(tmp - trial);
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = (RW+2)'(tmp);
        root_d = {root_q[RW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(RW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### sv/ppls_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a magnitude scaled by 2^22, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppls_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [ppls_pkg::MAG_W-1:0]          mag_i,
  input  logic [ppls_pkg::ROOT_W-1:0]         den_i,
  output logic                                done_o,
  output logic [ppls_pkg::QUOT_W-1:0]         quot_o
);

  localparam int unsigned RW = ppls_pkg::ROOT_W;
  localparam int unsigned QW = ppls_pkg::QUOT_W;

  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] den_q, den_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [RW:0]   tmp;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    tmp    = {rem_q, 1'b0};
    if (start_i) begin
      rem_d  = RW'({mag_i, 6'b0});
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (tmp >= {1'b0, den_q}) begin
        rem_d  = RW'(tmp - {1'b0, den_q});
        quot_d = {quot_q[QW-2:0], 1'b1};
      end else begin
        rem_d  = RW'(tmp);
        quot_d = {quot_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### sv/phong_point_light_shader.sv
// ----------------------------------------------------------------------------
// Phong point-light shader
// Accumulates Phong terms one point light per item and emits the shaded color
// on the item marked last.
// ----------------------------------------------------------------------------
// A lit light runs through a square root, three divisions and 34 steps on
// the one shared 32x32 multiplier (squares, dot products, reflection, an
// eight-bit power and the sum updates). An unlit light stops after the
// dot product of light and normal, and a light on the hit point stops after
// the squares. A light past MAX_LIGHTS is dropped. The closing item then
// computes the color on the multiplier before it is emitted. The input is
// not ready while a light is worked on. The result waits in an output
// register while the next lights are taken.
module phong_point_light_shader #(
  parameter int unsigned MAX_LIGHTS = ppls_pkg::MAX_LIGHTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [47:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // hit_point, surface_normal, view_direction, surface_color, light_position,
  // light_ambient, light_diffuse, light_specular
  input  logic [415:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // shade_red, shade_green, shade_blue
  output logic [47:0]  m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(MAX_LIGHTS + 1);
  localparam int unsigned SW    = ppls_pkg::SUM_W;

  ppls_pkg::state_e state_q, state_d;

  logic [47:0] mat_amb_q, mat_dif_q, mat_spec_q;
  logic [7:0]  shin_q;

  logic [62:0] hp_q, hp_d, lp_q, lp_d;
  logic [47:0] n_q, n_d, v_q, v_d, col_q, col_d;
  logic [47:0] la_q, la_d, ld_q, ld_d, ls_q, ls_d;
  logic        last_q, last_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]       idx_q, idx_d;
  logic             ph_q, ph_d;

  logic [SW-1:0]    amb_q [3];
  logic [SW-1:0]    amb_d [3];
  logic [SW-1:0]    dif_q [3];
  logic [SW-1:0]    dif_d [3];
  logic [SW-1:0]    spec_q [3];
  logic [SW-1:0]    spec_d [3];

  logic [43:0]        len2_q, len2_d;
  logic [ppls_pkg::ROOT_W-1:0] s_q, s_d;
  logic signed [16:0] l_q [3];
  logic signed [16:0] l_d [3];
  logic signed [25:0] r_q [3];
  logic signed [25:0] r_d [3];
  logic signed [43:0] dot_q, dot_d;
  logic [20:0]        lam_q, lam_d;
  logic [15:0]        b_q, b_d, p_q, p_d;
  logic [30:0]        t_q, t_d;
  logic [15:0]        out_q [3];
  logic [15:0]        out_d [3];
  logic               ov_q, ov_d;

  logic signed [ppls_pkg::MUL_W-1:0]  op_a, op_b;
  logic signed [ppls_pkg::PROD_W-1:0] prod;
  logic [ppls_pkg::PROD_W-1:0]        prod_u;

  logic                         sqrt_start, sqrt_done;
  logic [ppls_pkg::ROOT_W-1:0]  sqrt_root;
  logic                         div_start, div_done;
  logic [ppls_pkg::QUOT_W-1:0]  div_quot;
  logic [ppls_pkg::MAG_W-1:0]   div_mag;

  logic signed [21:0] dvec [3];
  logic [1:0]         ci, acc_c;
  logic [1:0]         fin_c, fin_k;
  logic signed [ppls_pkg::PROD_W-1:0] tzv;
  logic               accept;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign prod_u = $unsigned(prod);
  assign ci     = idx_q[1:0];
  assign acc_c  = (idx_q < 4'd3) ? idx_q[1:0] : 2'(idx_q - 4'd3);
  assign fin_c  = idx_q[3:2];
  assign fin_k  = idx_q[1:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dvec[c] = 22'(signed'(ppls_pkg::comp21(lp_q, 2'(c))))
              - 22'(signed'(ppls_pkg::comp21(hp_q, 2'(c))));
    end
  end

  assign div_mag = dvec[ci][21] ? 22'(-dvec[ci]) : 22'(dvec[ci]);

  ppls_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  ppls_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     ({len2_q, 18'b0}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  ppls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (div_mag),
    .den_i   (s_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      ppls_pkg::ST_SQ: begin
        op_a = 32'(dvec[ci]);
        op_b = 32'(dvec[ci]);
      end
      ppls_pkg::ST_LN: begin
        op_a = 32'(l_q[ci]);
        op_b = 32'(signed'(ppls_pkg::chan16(n_q, ci)));
      end
      ppls_pkg::ST_REFL: begin
        op_a = 32'(signed'(ppls_pkg::chan16(n_q, ci)));
        op_b = 32'(lam_q);
      end
      ppls_pkg::ST_VR: begin
        op_a = 32'(signed'(ppls_pkg::chan16(v_q, ci)));
        op_b = 32'(r_q[ci]);
      end
      ppls_pkg::ST_POW: begin
        op_a = 32'(p_q);
        if (!idx_q[0]) begin
          op_b = 32'(p_q);
        end else if (shin_q[~idx_q[3:1]]) begin
          op_b = 32'(b_q);
        end else begin
          op_b = 32'(ppls_pkg::ONE_Q13);
        end
      end
      ppls_pkg::ST_ACC: begin
        if (idx_q < 4'd3) begin
          op_a = 32'(ppls_pkg::chan16(ld_q, acc_c));
          op_b = 32'(lam_q);
        end else begin
          op_a = 32'(ppls_pkg::chan16(ls_q, acc_c));
          op_b = 32'(p_q);
        end
      end
      ppls_pkg::ST_FIN: begin
        case (fin_k)
          2'd0: begin
            op_a = 32'(amb_q[fin_c]);
            op_b = 32'(ppls_pkg::chan16(mat_amb_q, fin_c));
          end
          2'd1: begin
            op_a = 32'(dif_q[fin_c]);
            op_b = 32'(ppls_pkg::chan16(mat_dif_q, fin_c));
          end
          2'd2: begin
            op_a = 32'(spec_q[fin_c]);
            op_b = 32'(ppls_pkg::chan16(mat_spec_q, fin_c));
          end
          default: begin
            op_a = 32'(ppls_pkg::chan16(col_q, fin_c));
            op_b = 32'(t_q);
          end
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    hp_d       = hp_q;
    lp_d       = lp_q;
    n_d        = n_q;
    v_d        = v_q;
    col_d      = col_q;
    la_d       = la_q;
    ld_d       = ld_q;
    ls_d       = ls_q;
    last_d     = last_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    ph_d       = ph_q;
    amb_d      = amb_q;
    dif_d      = dif_q;
    spec_d     = spec_q;
    len2_d     = len2_q;
    s_d        = s_q;
    l_d        = l_q;
    r_d        = r_q;
    dot_d      = dot_q;
    lam_d      = lam_q;
    b_d        = b_q;
    p_d        = p_q;
    t_d        = t_q;
    out_d      = out_q;
    ov_d       = ov_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    tzv        = '0;
    s_axis_tready = (state_q == ppls_pkg::ST_IDLE);

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ppls_pkg::ST_IDLE: begin
        if (accept) begin
          hp_d   = s_axis_tdata[62:0];
          n_d    = s_axis_tdata[110:63];
          v_d    = s_axis_tdata[158:111];
          col_d  = s_axis_tdata[206:159];
          lp_d   = s_axis_tdata[269:207];
          la_d   = s_axis_tdata[317:270];
          ld_d   = s_axis_tdata[365:318];
          ls_d   = s_axis_tdata[413:366];
          last_d = s_axis_tlast;
          idx_d  = '0;
          ph_d   = 1'b0;
          t_d    = '0;
          if (cnt_q < CNT_W'(MAX_LIGHTS)) begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ppls_pkg::ST_AMB;
          end else if (s_axis_tlast) begin
            state_d = ppls_pkg::ST_FIN;
          end
        end
      end
      ppls_pkg::ST_AMB: begin
        for (int c = 0; c < 3; c++) begin
          amb_d[c] = ppls_pkg::sat_add(amb_q[c], 48'(ppls_pkg::chan16(la_q, 2'(c))));
        end
        len2_d  = '0;
        idx_d   = '0;
        ph_d    = 1'b0;
        state_d = ppls_pkg::ST_SQ;
      end
      ppls_pkg::ST_SQ: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          len2_d = len2_q + prod_u[43:0];
          idx_d  = idx_q + 4'd1;
          if (idx_q == 4'd2) begin
            idx_d = '0;
            if (len2_d == '0) begin
              state_d = last_q ? ppls_pkg::ST_FIN : ppls_pkg::ST_IDLE;
            end else begin
              state_d = ppls_pkg::ST_SQRT;
            end
          end
        end
      end
      ppls_pkg::ST_SQRT: begin
        if (!ph_q) begin
          sqrt_start = 1'b1;
          ph_d       = 1'b1;
        end else if (sqrt_done) begin
          s_d     = sqrt_root;
          ph_d    = 1'b0;
          state_d = ppls_pkg::ST_DIV;
        end
      end
      ppls_pkg::ST_DIV: begin
        if (!ph_q) begin
          div_start = 1'b1;
          ph_d      = 1'b1;
        end else if (div_done) begin
          l_d[ci] = dvec[ci][21] ? -17'(div_quot) : 17'(div_quot);
          ph_d    = 1'b0;
          idx_d   = idx_q + 4'd1;
          if (idx_q == 4'd2) begin
            idx_d   = '0;
            dot_d   = '0;
            state_d = ppls_pkg::ST_LN;
          end
        end
      end
      ppls_pkg::ST_LN: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          dot_d = dot_q + 44'(prod);
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd2) begin
            idx_d = '0;
            if (dot_d <= 0) begin
              state_d = last_q ? ppls_pkg::ST_FIN : ppls_pkg::ST_IDLE;
            end else begin
              lam_d   = dot_d[33:13];
              state_d = ppls_pkg::ST_REFL;
            end
          end
        end
      end
      ppls_pkg::ST_REFL: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          tzv     = (prod + (prod < 0 ? 64'sd4095 : 64'sd0)) >>> 12;
          r_d[ci] = 26'(l_q[ci]) - 26'(tzv);
          idx_d   = idx_q + 4'd1;
          if (idx_q == 4'd2) begin
            idx_d   = '0;
            dot_d   = '0;
            state_d = ppls_pkg::ST_VR;
          end
        end
      end
      ppls_pkg::ST_VR: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          dot_d = dot_q + 44'(prod);
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd2) begin
            idx_d = '0;
            tzv   = 64'(dot_d) >>> 13;
            if (dot_d < 0) begin
              b_d = '0;
            end else begin
              b_d = ppls_pkg::sat16(64'(tzv));
            end
            p_d     = ppls_pkg::ONE_Q13;
            state_d = ppls_pkg::ST_POW;
          end
        end
      end
      ppls_pkg::ST_POW: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          p_d   = ppls_pkg::sat16(prod_u >> 13);
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd15) begin
            idx_d   = '0;
            state_d = ppls_pkg::ST_ACC;
          end
        end
      end
      ppls_pkg::ST_ACC: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (idx_q < 4'd3) begin
            dif_d[acc_c] = ppls_pkg::sat_add(dif_q[acc_c], prod_u[60:13]);
          end else begin
            spec_d[acc_c] = ppls_pkg::sat_add(spec_q[acc_c], prod_u[60:13]);
          end
          idx_d = idx_q + 4'd1;
          if (idx_q == 4'd5) begin
            idx_d   = '0;
            t_d     = '0;
            state_d = last_q ? ppls_pkg::ST_FIN : ppls_pkg::ST_IDLE;
          end
        end
      end
      ppls_pkg::ST_FIN: begin
        if (!(idx_q == 4'd0 && !ph_q && ov_q)) begin
          ph_d = ~ph_q;
          if (ph_q) begin
            idx_d = idx_q + 4'd1;
            if (fin_k == 2'd3) begin
              out_d[fin_c] = ppls_pkg::sat16(prod_u >> 12);
              t_d          = '0;
            end else begin
              t_d = t_q + 31'(prod_u >> 12);
            end
            if (idx_q == 4'd11) begin
              idx_d = '0;
              ov_d  = 1'b1;
              cnt_d = '0;
              for (int c = 0; c < 3; c++) begin
                amb_d[c]  = '0;
                dif_d[c]  = '0;
                spec_d[c] = '0;
              end
              state_d = ppls_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ppls_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ppls_pkg::ST_IDLE;
      mat_amb_q  <= ppls_pkg::ONE3_Q412;
      mat_dif_q  <= ppls_pkg::ONE3_Q412;
      mat_spec_q <= ppls_pkg::ONE3_Q412;
      shin_q     <= ppls_pkg::SHIN_RESET;
      cnt_q      <= '0;
      idx_q      <= '0;
      ph_q       <= 1'b0;
      ov_q       <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        amb_q[c]  <= '0;
        dif_q[c]  <= '0;
        spec_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ph_q    <= ph_d;
      ov_q    <= ov_d;
      amb_q   <= amb_d;
      dif_q   <= dif_d;
      spec_q  <= spec_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ppls_pkg::REG_MAT_AMB:  mat_amb_q  <= cfg_data_i;
          ppls_pkg::REG_MAT_DIF:  mat_dif_q  <= cfg_data_i;
          ppls_pkg::REG_MAT_SPEC: mat_spec_q <= cfg_data_i;
          ppls_pkg::REG_SHIN:     shin_q     <= cfg_data_i[7:0];
          default:                shin_q     <= shin_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hp_d_hold: begin
      hp_q   <= hp_d;
      lp_q   <= lp_d;
      n_q    <= n_d;
      v_q    <= v_d;
      col_q  <= col_d;
      la_q   <= la_d;
      ld_q   <= ld_d;
      ls_q   <= ls_d;
      last_q <= last_d;
      len2_q <= len2_d;
      s_q    <= s_d;
      l_q    <= l_d;
      r_q    <= r_d;
      dot_q  <= dot_d;
      lam_q  <= lam_d;
      b_q    <= b_d;
      p_q    <= p_d;
      t_q    <= t_d;
      out_q  <= out_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

endmodule
